// ===== src/pwm_timer_with_prescaler_macros.svh =====
// Assertion macros shared by the timer's checker.
`ifndef PWM_TIMER_WITH_PRESCALER_MACROS_SVH
`define PWM_TIMER_WITH_PRESCALER_MACROS_SVH

// Same-cycle implication, sampled on aclk, disabled during reset.
`define PWMT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, disabled during reset.
`define PWMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pwmt_pkg.sv =====
// Shared types and constants of the PWM timer.
package pwmt_pkg;

    localparam int unsigned ValWidth = 16;

    typedef enum logic [2:0] {
        ACT_TICK         = 3'd0,
        ACT_SET_COUNT    = 3'd1,
        ACT_SET_DUTY     = 3'd2,
        ACT_START        = 3'd3,
        ACT_STOP         = 3'd4,
        ACT_FORCE_UPDATE = 3'd5
    } action_t;

    localparam logic [1:0] CFG_PRESCALE = 2'd0;
    localparam logic [1:0] CFG_RELOAD   = 2'd1;
    localparam logic [1:0] CFG_OUT_EN   = 2'd2;

    localparam logic [ValWidth-1:0] RELOAD_RESET = 16'hFFFF;

    // Commands from the counter section to the duty registers.
    typedef struct packed {
        logic                wr;
        logic [1:0]          chan;
        logic [ValWidth-1:0] val;
        logic                load;
    } duty_ctl_t;

endpackage

// ===== src/pwmt_channels.sv =====
// Duty preload and active registers with the mode 1 compare of each channel.
module pwmt_channels #(
    parameter int NUM_CHANNELS = 4,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pwmt_pkg::duty_ctl_t    ctl,
    input  logic [COUNT_WIDTH-1:0] count_next,
    input  logic [3:0]             enable_mask,
    output logic [3:0]             levels
);
    import pwmt_pkg::*;

    localparam int CmpWidth = (COUNT_WIDTH > ValWidth) ? COUNT_WIDTH : ValWidth;

    logic [ValWidth-1:0] duty_preload_reg [NUM_CHANNELS];
    logic [ValWidth-1:0] duty_active_reg  [NUM_CHANNELS];
    logic [ValWidth-1:0] duty_active_next [NUM_CHANNELS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                duty_preload_reg[i] <= '0;
                duty_active_reg[i]  <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (ctl.wr && ctl.chan == 2'(i)) begin
                    duty_preload_reg[i] <= ctl.val;
                end
                duty_active_reg[i] <= duty_active_next[i];
            end
        end
    end

    // The compare sees the active duty as it stands after this beat.
    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            duty_active_next[i] = ctl.load ? duty_preload_reg[i] : duty_active_reg[i];
        end
    end

    for (genvar i = 0; i < 4; i++) begin : g_level
        if (i < NUM_CHANNELS) begin : g_used
            assign levels[i] = enable_mask[i] &&
                (CmpWidth'(count_next) < CmpWidth'(duty_active_next[i]));
        end else begin : g_unused
            assign levels[i] = 1'b0;
        end
    end

endmodule

// ===== src/pwm_timer_with_prescaler.sv =====
// Top level of the 16-bit prescaled auto-reload timer with four PWM outputs.
//
// Each input beat is one command: a clock tick, a counter write, a duty write, start, stop or
// a forced update. The block returns exactly one result beat per command, carrying the counter
// value, the four PWM levels, the update flag and the run flag as they stand after that command.
// A new beat is accepted every cycle while the result side keeps up; a result passes through
// one input register and one result register, and the counter, prescaler and duty state close
// their feedback loop between those two registers. While a finished result waits for m_tready,
// the input register can still take one more beat; after that s_tready stays low until the
// waiting result is taken. Counting up runs
// 0 to reload and wraps to 0; counting down runs from reload to 0 and then reloads. Each wrap,
// and each forced update, copies the preloaded duties into the active compare registers.
// Configuration writes (prescaler, reload, output enables) must only be made while no beat
// is in flight. There is no clearing pass after reset.
module pwm_timer_with_prescaler #(
    parameter int NUM_CHANNELS = 4,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] value, [16] start_direction, [23:17] zero
    input  logic [4:0]  s_tuser,   // [2:0] action, [4:3] channel
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] count_now, [19:16] pwm_levels,
                                   // [20] update_event, [21] is_running, [23:22] zero
    // Register writes.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import pwmt_pkg::*;

    localparam int CmpWidth = (COUNT_WIDTH > ValWidth) ? COUNT_WIDTH : ValWidth;

    // Configuration registers.
    logic [ValWidth-1:0] prescale_reg;
    logic [ValWidth-1:0] reload_reg;
    logic [3:0]          out_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg <= '0;
            reload_reg   <= RELOAD_RESET;
            out_en_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PRESCALE: prescale_reg <= cfg_wdata;
                CFG_RELOAD:   reload_reg   <= cfg_wdata;
                CFG_OUT_EN:   out_en_reg   <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Input register. Its beat moves on whenever the result register can take a new result.
    logic                s1_valid_reg;
    action_t             s1_action_reg;
    logic [1:0]          s1_channel_reg;
    logic [ValWidth-1:0] s1_value_reg;
    logic                s1_dir_reg;

    logic out_valid_reg;
    logic out_free;
    logic advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            s1_valid_reg <= 1'b1;
        end else if (advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s1_action_reg  <= action_t'(s_tuser[2:0]);
            s1_channel_reg <= s_tuser[4:3];
            s1_value_reg   <= s_tdata[15:0];
            s1_dir_reg     <= s_tdata[16];
        end
    end

    // Timer state.
    logic [COUNT_WIDTH-1:0] counter_reg, counter_next;
    logic [ValWidth-1:0]    presc_cnt_reg, presc_cnt_next;
    logic                   run_reg, run_next;
    logic                   down_reg, down_next;
    logic                   update;

    logic [CmpWidth-1:0]    reload_ext;
    logic [CmpWidth-1:0]    value_ext;
    logic [COUNT_WIDTH-1:0] top;
    logic [COUNT_WIDTH-1:0] value_cnt;

    // The reload value and counter writes are cut to the counter width.
    assign reload_ext = CmpWidth'(reload_reg);
    assign value_ext  = CmpWidth'(s1_value_reg);
    assign top        = reload_ext[COUNT_WIDTH-1:0];
    assign value_cnt  = value_ext[COUNT_WIDTH-1:0];

    always_comb begin
        counter_next   = counter_reg;
        presc_cnt_next = presc_cnt_reg;
        run_next       = run_reg;
        down_next      = down_reg;
        update         = 1'b0;
        unique case (s1_action_reg)
            ACT_TICK: begin
                if (run_reg) begin
                    // A prescaler left above a lowered limit steps on the next tick.
                    if (presc_cnt_reg >= prescale_reg) begin
                        presc_cnt_next = '0;
                        if (down_reg) begin
                            if (counter_reg == '0) begin
                                counter_next = top;
                                update       = 1'b1;
                            end else begin
                                counter_next = counter_reg - 1'b1;
                            end
                        end else if (counter_reg >= top) begin
                            counter_next = '0;
                            update       = 1'b1;
                        end else begin
                            counter_next = counter_reg + 1'b1;
                        end
                    end else begin
                        presc_cnt_next = presc_cnt_reg + 1'b1;
                    end
                end
            end
            ACT_SET_COUNT:    counter_next = value_cnt;
            ACT_SET_DUTY:     ;
            ACT_START: begin
                run_next  = 1'b1;
                down_next = s1_dir_reg;
            end
            ACT_STOP:         run_next = 1'b0;
            ACT_FORCE_UPDATE: begin
                counter_next   = '0;
                presc_cnt_next = '0;
                update         = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg   <= '0;
            presc_cnt_reg <= '0;
            run_reg       <= 1'b0;
            down_reg      <= 1'b0;
        end else if (advance) begin
            counter_reg   <= counter_next;
            presc_cnt_reg <= presc_cnt_next;
            run_reg       <= run_next;
            down_reg      <= down_next;
        end
    end

    // Duty registers and compare.
    duty_ctl_t  duty_ctl;
    logic [3:0] levels;

    assign duty_ctl.wr   = advance && (s1_action_reg == ACT_SET_DUTY);
    assign duty_ctl.chan = s1_channel_reg;
    assign duty_ctl.val  = s1_value_reg;
    assign duty_ctl.load = advance && update;

    pwmt_channels #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_channels (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (duty_ctl),
        .count_next  (counter_next),
        .enable_mask (out_en_reg),
        .levels      (levels)
    );

    // Result register.
    logic [CmpWidth-1:0] count_ext;
    logic [21:0]         out_data_reg;

    assign count_ext = CmpWidth'(counter_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {run_next, update, levels, count_ext[15:0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

endmodule

// ===== src/pwmt_checker.sv =====
// Port-level checker for the PWM timer, bound to its top level.
`include "pwm_timer_with_prescaler_macros.svh"

module pwmt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A stalled result beat keeps its value.
    `PWMT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // Nothing is offered right after reset.
    `PWMT_ASSERT_IMPL(a_reset_empty, $past(!aresetn), !m_tvalid, "result offered after reset")

    // With the sink ready, the input side is never held off.
    `PWMT_ASSERT_IMPL(a_no_stall, m_tready, s_tready, "input stalled while sink ready")

    // A taken beat reaches the output through the input and result registers when the sink keeps up.
    `PWMT_ASSERT_NEXT(a_latency, (s_tvalid && s_tready) ##1 m_tready, m_tvalid, "result beat missing after two cycles")

endmodule

bind pwm_timer_with_prescaler pwmt_checker u_pwmt_checker (.*);

// ===== verif/tb_pwm_timer_with_prescaler.sv =====
// Self-checking testbench of the prescaled PWM timer: command stream in, one result beat each.
module tb_pwm_timer_with_prescaler;

    timeunit 1ns;
    timeprecision 1ps;

    import pwmt_pkg::*;

    localparam int NUM_CH = 4;

    // Action codes 6 and 7 have no meaning in the block and must behave as no-ops.
    localparam logic [2:0] ACT_NOP_SIX   = 3'd6;
    localparam logic [2:0] ACT_NOP_SEVEN = 3'd7;

    // Register index 3 is not implemented; writes to it must be dropped.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int ITEMS_PER_SET  = 210;
    localparam int NUM_RAND_SETS  = 8;
    localparam int LONG_HOLD      = 120;

    // One command beat as the block sees it.
    typedef struct packed {
        logic [2:0]  action;
        logic [1:0]  chan;
        logic [15:0] value;
        logic        dir;
    } timer_cmd_t;

    // One result beat, split into its fields.
    typedef struct packed {
        logic [15:0] count;
        logic [3:0]  levels;
        logic        update;
        logic        running;
    } timer_result_t;

    // The scoreboard carries its own copy of the timer: the registers, the counter and
    // prescaler, the run and direction flags and both banks of duty registers. Every
    // accepted command advances that copy and queues the result the block owes for it.
    class timer_tracker;
        logic [15:0]   prescale;
        logic [15:0]   reload;
        logic [3:0]    out_en;
        logic [15:0]   count;
        logic [15:0]   prescale_cnt;
        bit            running;
        bit            counting_down;
        logic [15:0]   duty_next [NUM_CH];
        logic [15:0]   duty_live [NUM_CH];
        timer_result_t owed_results [$];
        int            errors;
        int            checked;
        int            updates_seen;

        function new();
            prescale      = '0;
            reload        = RELOAD_RESET;
            out_en        = '0;
            count         = '0;
            prescale_cnt  = '0;
            running       = 1'b0;
            counting_down = 1'b0;
            for (int i = 0; i < NUM_CH; i++) begin
                duty_next[i] = '0;
                duty_live[i] = '0;
            end
            errors       = 0;
            checked      = 0;
            updates_seen = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_PRESCALE: prescale = data;
                CFG_RELOAD:   reload   = data;
                CFG_OUT_EN:   out_en   = data[3:0];
                default: ;
            endcase
        endfunction

        // One counter step; returns 1 when the counter wraps.
        function bit step_count();
            if (counting_down) begin
                if (count == '0) begin
                    count = reload;
                    return 1'b1;
                end
                count = count - 16'd1;
                return 1'b0;
            end
            // Counting up, anything at or above the reload value wraps to zero.
            if (count >= reload) begin
                count = '0;
                return 1'b1;
            end
            count = count + 16'd1;
            return 1'b0;
        endfunction

        function void note_command(timer_cmd_t c);
            timer_result_t r;
            bit            upd;
            upd = 1'b0;
            case (c.action)
                ACT_TICK: begin
                    if (running) begin
                        // A prescaler left above a lowered limit steps on the next tick.
                        if (prescale_cnt >= prescale) begin
                            prescale_cnt = '0;
                            upd = step_count();
                        end else begin
                            prescale_cnt = prescale_cnt + 16'd1;
                        end
                    end
                end
                ACT_SET_COUNT:    count = c.value;
                ACT_SET_DUTY:     duty_next[c.chan] = c.value;
                ACT_START: begin
                    running       = 1'b1;
                    counting_down = c.dir;
                end
                ACT_STOP:         running = 1'b0;
                ACT_FORCE_UPDATE: begin
                    count        = '0;
                    prescale_cnt = '0;
                    upd          = 1'b1;
                end
                default: ;
            endcase
            if (upd) begin
                for (int i = 0; i < NUM_CH; i++) duty_live[i] = duty_next[i];
                updates_seen++;
            end
            r.count   = count;
            r.update  = upd;
            r.running = running;
            for (int i = 0; i < NUM_CH; i++) r.levels[i] = out_en[i] && (count < duty_live[i]);
            owed_results.push_back(r);
        endfunction

        function void check_result(logic [23:0] beat);
            timer_result_t got;
            timer_result_t want;
            got.count   = beat[15:0];
            got.levels  = beat[19:16];
            got.update  = beat[20];
            got.running = beat[21];
            if (owed_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result beat with nothing owed: count=%h levels=%b upd=%b run=%b",
                             got.count, got.levels, got.update, got.running);
                return;
            end
            want = owed_results.pop_front();
            checked++;
            if (got.count !== want.count || got.levels !== want.levels ||
                got.update !== want.update || got.running !== want.running) begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: result %0d: expected count=%h levels=%b upd=%b run=%b, ",
                              "got count=%h levels=%b upd=%b run=%b"}, checked,
                             want.count, want.levels, want.update, want.running,
                             got.count, got.levels, got.update, got.running);
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // [15:0] value, [16] start_direction, [23:17] zero
    logic [4:0]  s_tuser   = '0;   // [2:0] action, [4:3] channel
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // [15:0] count_now, [19:16] pwm_levels, [20] update_event,
                                   // [21] is_running, [23:22] zero
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    timer_tracker tracker = new();

    int cycle_count  = 0;
    int beats_in     = 0;
    int stall_cycles = 0;
    int long_holds   = 0;
    int settings     = 0;

    pwm_timer_with_prescaler uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // Result monitor. Outputs are read right after the edge, so they hold the values the
    // block presented at that edge. Input back-pressure is tallied here as well.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) tracker.check_result(m_tdata);
            if (s_tvalid && !s_tready) stall_cycles++;
        end
    end

    // Result sink. It drifts between stall styles of random length: always ready, a coin
    // flip, mostly stalled and a fixed one-in-three pattern. Twice in the run it refuses
    // results for a long stretch so the block backs up and has to stall its input.
    initial begin : result_sink
        int hold_left;
        int style;
        int style_left;
        int pattern_pos;
        int next_hold_at;
        hold_left    = 0;
        style        = 0;
        style_left   = 0;
        pattern_pos  = 0;
        next_hold_at = 400;
        forever begin
            @(posedge aclk);
            if (hold_left == 0 && beats_in >= next_hold_at) begin
                hold_left    = LONG_HOLD;
                next_hold_at = next_hold_at + 900;
                long_holds++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (style_left == 0) begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(16, 96);
                end
                style_left--;
                pattern_pos++;
                case (style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= ($urandom_range(0, 4) == 0);
                    default: m_tready <= (pattern_pos % 3 != 0);
                endcase
            end
        end
    end

    // Offers one command and returns at the edge where it was taken. The valid stays high,
    // so back-to-back calls form a burst; pause_input ends a burst.
    task automatic send_cmd(timer_cmd_t c);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, c.dir, c.value};
        s_tuser  <= {c.chan, c.action};
        do @(posedge aclk); while (!s_tready);
        tracker.note_command(c);
        beats_in++;
    endtask

    task automatic send(logic [2:0] action, logic [1:0] chan, logic [15:0] value, logic dir);
        timer_cmd_t c;
        c.action = action;
        c.chan   = chan;
        c.value  = value;
        c.dir    = dir;
        send_cmd(c);
    endtask

    task automatic pause_input(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Registers may only change with nothing in flight: stop offering and wait until
    // every owed result has been returned.
    task automatic drain();
        pause_input(1);
        while (tracker.owed_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        tracker.write_reg(idx, data);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_setting(logic [15:0] prescale, logic [15:0] reload, logic [3:0] mask);
        drain();
        write_reg(CFG_PRESCALE, prescale);
        write_reg(CFG_RELOAD, reload);
        // Upper bits of the enable write are junk that the block must drop.
        write_reg(CFG_OUT_EN, {12'($urandom_range(0, 4095)), mask});
        settings++;
    endtask

    // Random command, weighted toward ticks. Counter and duty values land near the
    // current period half of the time so compares and wraps actually happen.
    function automatic timer_cmd_t random_cmd(logic [15:0] reach);
        timer_cmd_t c;
        int         pick;
        int         lim;
        lim  = int'(reach) + 2;
        if (lim > 65535) lim = 65535;
        pick = $urandom_range(0, 99);
        c.chan  = 2'($urandom_range(0, 3));
        c.dir   = 1'($urandom_range(0, 1));
        c.value = 16'($urandom);
        if (pick < 62)      c.action = ACT_TICK;
        else if (pick < 68) c.action = ACT_SET_COUNT;
        else if (pick < 78) c.action = ACT_SET_DUTY;
        else if (pick < 84) c.action = ACT_START;
        else if (pick < 88) c.action = ACT_STOP;
        else if (pick < 95) c.action = ACT_FORCE_UPDATE;
        else                c.action = ($urandom_range(0, 1) == 1) ? ACT_NOP_SIX : ACT_NOP_SEVEN;
        if ((c.action == ACT_SET_COUNT || c.action == ACT_SET_DUTY) && $urandom_range(0, 1) == 1)
            c.value = 16'($urandom_range(0, lim));
        return c;
    endfunction

    // One random phase: start the timer, then stream commands in bursts of random length
    // separated by random gaps, with some bursts running straight into the next.
    task automatic random_phase(logic [15:0] prescale, logic [15:0] reload, logic [3:0] mask);
        int burst_left;
        int gap;
        burst_left = 0;
        apply_setting(prescale, reload, mask);
        send(ACT_START, 2'($urandom_range(0, 3)), 16'($urandom), 1'($urandom_range(0, 1)));
        for (int n = 1; n < ITEMS_PER_SET; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) pause_input(gap);
            end
            burst_left--;
            send_cmd(random_cmd(reload));
        end
    endtask

    initial begin : stimulus
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The unimplemented register index must be ignored.
        write_reg(CFG_UNUSED, 16'hFFFF);
        apply_setting(16'h0000, 16'hFFFF, 4'hF);

        // Ticks do nothing while stopped; the odd action codes only report state.
        send(ACT_TICK, 2'd0, 16'h0000, 1'b0);
        send(ACT_NOP_SIX, 2'd3, 16'hFFFF, 1'b1);
        // Duties go to the preload bank and only take effect on the forced update.
        send(ACT_SET_DUTY, 2'd0, 16'hFFFF, 1'b0);
        send(ACT_SET_DUTY, 2'd1, 16'h0000, 1'b1);
        send(ACT_SET_DUTY, 2'd2, 16'h8000, 1'b0);
        send(ACT_SET_DUTY, 2'd3, 16'h0001, 1'b1);
        send(ACT_TICK, 2'd0, 16'h0000, 1'b0);
        send(ACT_FORCE_UPDATE, 2'd0, 16'h0000, 1'b0);
        // Counting up from the top of the range wraps to zero with an update.
        send(ACT_SET_COUNT, 2'd0, 16'hFFFF, 1'b0);
        send(ACT_START, 2'd0, 16'h0000, 1'b0);
        send(ACT_TICK, 2'd0, 16'h0000, 1'b0);
        send(ACT_TICK, 2'd0, 16'h0000, 1'b0);
        send(ACT_NOP_SEVEN, 2'd1, 16'h5555, 1'b0);
        // Counting down through zero reloads.
        send(ACT_START, 2'd0, 16'h0000, 1'b1);
        send(ACT_TICK, 2'd0, 16'h0000, 1'b0);
        send(ACT_TICK, 2'd0, 16'h0000, 1'b0);
        send(ACT_STOP, 2'd0, 16'h0000, 1'b0);
        send(ACT_TICK, 2'd0, 16'h0000, 1'b0);

        // A counter above the reload value while counting up; the prescaler is left at 3.
        apply_setting(16'd3, 16'd10, 4'h5);
        send(ACT_SET_COUNT, 2'd0, 16'hFFFF, 1'b0);
        send(ACT_START, 2'd0, 16'h0000, 1'b0);
        send(ACT_TICK, 2'd0, 16'h0000, 1'b0);
        send(ACT_TICK, 2'd0, 16'h0000, 1'b0);
        send(ACT_TICK, 2'd0, 16'h0000, 1'b0);
        // Lowering the prescale limit below the running prescaler makes the next tick step.
        apply_setting(16'd1, 16'd10, 4'hA);
        send(ACT_TICK, 2'd0, 16'h0000, 1'b0);
        // Counting down from above the reload value just decrements.
        send(ACT_SET_COUNT, 2'd0, 16'h8000, 1'b0);
        send(ACT_START, 2'd0, 16'h0000, 1'b1);
        send(ACT_TICK, 2'd0, 16'h0000, 1'b0);
        send(ACT_TICK, 2'd0, 16'h0000, 1'b0);

        // Random phases over settings ranging from the tightest period and fastest prescale to the widest.
        for (int p = 0; p < NUM_RAND_SETS; p++) begin
            case (p)
                0: random_phase(16'd0, 16'd0, 4'hF);
                1: random_phase(16'hFFFF, 16'hFFFF, 4'h0);
                2: random_phase(16'd0, 16'd7, 4'hF);
                3: random_phase(16'd1, 16'd30, 4'h5);
                4: random_phase(16'd2, 16'd100, 4'hA);
                5: random_phase(16'd0, 16'd3, 4'hF);
                6: random_phase(16'($urandom_range(0, 3)), 16'($urandom_range(0, 300)),
                                4'($urandom_range(0, 15)));
                default: random_phase(16'($urandom_range(0, 4)), 16'($urandom),
                                      4'($urandom_range(0, 15)));
            endcase
        end

        // Wait for every owed result, then keep the monitor running to catch anything stray.
        drain();
        repeat (10) @(posedge aclk);

        $display("Run covered %0d commands under %0d register settings; %0d results checked, %0d update events.",
                 beats_in, settings, tracker.checked, tracker.updates_seen);
        $display("Input was back-pressured for %0d cycles, including %0d long result holds.",
                 stall_cycles, long_holds);
        if (tracker.errors == 0 && tracker.owed_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("Errors: %0d, results still owed: %0d",
                     tracker.errors, tracker.owed_results.size());
            $display("FAILURE");
        end
        $finish;
    end

    // Give up if the run does not finish well within the slowest legal timing.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("Timeout after %0d cycles with %0d results still owed",
                 cycle_count, tracker.owed_results.size());
        $display("FAILURE");
        $finish;
    end

endmodule
